### src/pfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types and codes for the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

    localparam int CFG_AW = 2;

    // request modes
    localparam logic [2:0] MODE_ALLOC   = 3'd0;
    localparam logic [2:0] MODE_RELEASE = 3'd1;
    localparam logic [2:0] MODE_PIN     = 3'd2;
    localparam logic [2:0] MODE_UNPIN   = 3'd3;
    localparam logic [2:0] MODE_COUNT   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_FRAMES_IN_USE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PINS_BLOCK    = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RECOUNT
    } state_t;

    typedef struct packed {
        logic load;      // capture request and free-frame snapshot
        logic exec;      // apply request, write result register
        logic wr_limit;  // write frames_in_use
        logic wr_pins;   // write pins_block_alloc
        logic rc_clear;  // restart recount chunk counter
        logic rc_step;   // fold one chunk into the open count
    } ctl_cmd_t;

    typedef struct packed {
        logic rc_last;   // recount is on its last chunk
    } dp_status_t;

endpackage

### src/pfba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_ctrl
// Sequencer for request execution, configuration writes and open recount.
// ----------------------------------------------------------------------------
module pfba_ctrl
    import pfba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    output logic              m_valid,
    input  logic              m_ready,
    input  dp_status_t        status,
    output ctl_cmd_t          cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    if (cfg_addr == CFG_FRAMES_IN_USE) begin
                        state_next = ST_RECOUNT;
                    end
                end else if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RECOUNT: begin
                if (status.rc_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready    = 1'b1;
                s_ready      = !cfg_valid;
                cmd.load     = s_valid && !cfg_valid;
                cmd.wr_limit = cfg_valid && (cfg_addr == CFG_FRAMES_IN_USE);
                cmd.wr_pins  = cfg_valid && (cfg_addr == CFG_PINS_BLOCK);
                cmd.rc_clear = cfg_valid && (cfg_addr == CFG_FRAMES_IN_USE);
            end
            ST_EXEC: begin
                cmd.exec = out_free;
            end
            ST_RECOUNT: begin
                cmd.rc_step = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

### src/pfba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_datapath
// Bitmaps, counters, first-fit search and result register.
// ----------------------------------------------------------------------------
module pfba_datapath
    import pfba_pkg::*;
#(
    parameter int FRAME_COUNT = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctl_cmd_t   cmd,
    output dp_status_t status,
    input  logic [6:0] cfg_wdata,
    input  logic [2:0] s_mode,
    input  logic [5:0] s_frame_index,
    input  logic       s_add_pinned,
    output logic       m_ok,
    output logic [5:0] m_granted_frame,
    output logic [7:0] m_open_count
);

    localparam int NF  = (FRAME_COUNT < 64) ? FRAME_COUNT : 64;
    localparam int NCH = (NF + 7) / 8;
    localparam int PW  = NCH * 8;
    localparam int IW  = $clog2(NF);
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [6:0] NF_W = 7'(NF);

    logic [NF-1:0]  alloc_reg, alloc_next;
    logic [NF-1:0]  pinned_reg, pinned_next;
    logic [6:0]     limit_reg;
    logic           pins_blk_reg;
    logic [6:0]     open_reg, open_next;
    logic [6:0]     pin_cnt_reg, pin_cnt_next;
    logic [2:0]     req_mode_reg;
    logic [5:0]     req_frame_reg;
    logic           req_add_reg;
    logic [PW-1:0]  free_reg;
    logic [NCH-1:0] grp_any_reg;
    logic [CW-1:0]  rc_idx_reg;
    logic           out_ok_reg;
    logic [5:0]     out_frame_reg;
    logic [7:0]     out_count_reg;

    logic [6:0]     lim;
    logic [PW-1:0]  lim_mask;
    logic [PW-1:0]  alloc_pad;
    logic [PW-1:0]  free_now;
    logic [NCH-1:0] grp_any_now;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'd0, v[k]};
        end
        return n;
    endfunction

    assign lim       = (limit_reg > NF_W) ? NF_W : limit_reg;
    assign alloc_pad = PW'(alloc_reg);

    always_comb begin
        for (int i = 0; i < PW; i++) begin
            lim_mask[i] = (i < NF) ? (7'(i) < lim) : 1'b0;
        end
    end

    assign free_now = ~alloc_pad & lim_mask;

    always_comb begin
        for (int g = 0; g < NCH; g++) begin
            grp_any_now[g] = |free_now[g*8 +: 8];
        end
    end

    // first fit: lowest nonempty byte, then lowest bit in it
    logic [2:0] sel_g;
    logic [2:0] sel_b;
    logic [7:0] sel_byte;
    logic       found;
    logic [5:0] grant;
    logic [IW-1:0] grant_idx;

    always_comb begin
        sel_g    = 3'd0;
        sel_byte = 8'd0;
        for (int g = NCH - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                sel_g    = 3'(g);
                sel_byte = free_reg[g*8 +: 8];
            end
        end
        sel_b = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (sel_byte[b]) begin
                sel_b = 3'(b);
            end
        end
    end

    assign found     = |grp_any_reg;
    assign grant     = {sel_g, sel_b};
    assign grant_idx = grant[IW-1:0];

    logic [IW-1:0] fr_idx;
    logic          in_range;
    logic          a_bit;
    logic          p_bit;
    logic          g_pin;
    logic          ok_c;
    logic [5:0]    gr_c;
    logic [7:0]    count_c;

    assign fr_idx   = req_frame_reg[IW-1:0];
    assign in_range = ({1'b0, req_frame_reg} < lim);
    assign a_bit    = in_range && alloc_reg[fr_idx];
    assign p_bit    = in_range && pinned_reg[fr_idx];
    assign g_pin    = found && pinned_reg[grant_idx];

    // recount chunk
    logic [7:0] rc_chunk;
    logic [3:0] rc_pc;

    always_comb begin
        rc_chunk = 8'd0;
        for (int g = 0; g < NCH; g++) begin
            if (CW'(g) == rc_idx_reg) begin
                rc_chunk = alloc_pad[g*8 +: 8] & lim_mask[g*8 +: 8];
            end
        end
    end

    assign rc_pc          = pop8(rc_chunk);
    assign status.rc_last = (rc_idx_reg == CW'(NCH - 1));

    always_comb begin
        alloc_next   = alloc_reg;
        pinned_next  = pinned_reg;
        open_next    = open_reg;
        pin_cnt_next = pin_cnt_reg;
        ok_c         = 1'b0;
        gr_c         = 6'd0;
        if (cmd.rc_step) begin
            open_next = ((rc_idx_reg == '0) ? lim : open_reg) - {3'd0, rc_pc};
        end else begin
            case (req_mode_reg)
                MODE_ALLOC: begin
                    if (found && !(pins_blk_reg && g_pin)) begin
                        alloc_next[grant_idx] = 1'b1;
                        if (open_reg != 7'd0) begin
                            open_next = open_reg - 7'd1;
                        end
                        ok_c = 1'b1;
                        gr_c = grant;
                    end
                end
                MODE_RELEASE: begin
                    if (in_range) begin
                        if (a_bit) begin
                            alloc_next[fr_idx] = 1'b0;
                            if (open_reg != 7'd127) begin
                                open_next = open_reg + 7'd1;
                            end
                        end
                        ok_c = 1'b1;
                    end
                end
                MODE_PIN: begin
                    if (in_range && !p_bit) begin
                        pinned_next[fr_idx] = 1'b1;
                        pin_cnt_next        = pin_cnt_reg + 7'd1;
                        ok_c                = 1'b1;
                    end
                end
                MODE_UNPIN: begin
                    if (p_bit) begin
                        pinned_next[fr_idx] = 1'b0;
                        pin_cnt_next        = pin_cnt_reg - 7'd1;
                        ok_c                = 1'b1;
                    end
                end
                MODE_COUNT: begin
                    ok_c = 1'b1;
                end
                default: begin
                end
            endcase
        end
        count_c = {1'b0, open_next};
        if (req_mode_reg == MODE_COUNT && req_add_reg) begin
            count_c = count_c + {1'b0, pin_cnt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg    <= '0;
            pinned_reg   <= '0;
            limit_reg    <= 7'd64;
            pins_blk_reg <= 1'b1;
            open_reg     <= NF_W;
            pin_cnt_reg  <= 7'd0;
            rc_idx_reg   <= '0;
        end else begin
            if (cmd.exec) begin
                alloc_reg   <= alloc_next;
                pinned_reg  <= pinned_next;
                open_reg    <= open_next;
                pin_cnt_reg <= pin_cnt_next;
            end
            if (cmd.rc_step) begin
                open_reg   <= open_next;
                rc_idx_reg <= rc_idx_reg + CW'(1);
            end
            if (cmd.rc_clear) begin
                rc_idx_reg <= '0;
            end
            if (cmd.wr_limit) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.wr_pins) begin
                pins_blk_reg <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_mode_reg  <= s_mode;
            req_frame_reg <= s_frame_index;
            req_add_reg   <= s_add_pinned;
            free_reg      <= free_now;
            grp_any_reg   <= grp_any_now;
        end
        if (cmd.exec) begin
            out_ok_reg    <= ok_c;
            out_frame_reg <= gr_c;
            out_count_reg <= count_c;
        end
    end

    assign m_ok            = out_ok_reg;
    assign m_granted_frame = out_frame_reg;
    assign m_open_count    = out_count_reg;

endmodule

### src/page_frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// First-fit page frame allocator with allocated and pinned bitmaps.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken in the idle state, where the free
// map is snapshotted, and executed in the exec state, which waits until the
// result register is free and then loads it. The first-fit search runs as a
// byte-group pick and a bit pick on the snapshot. Writing frames_in_use
// starts a recount of open frames, one byte of the allocated map per cycle;
// no request or configuration write is taken until it finishes.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_core
    import pfba_pkg::*;
#(
    parameter int FRAME_COUNT = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_mode,
    input  logic [5:0]        s_frame_index,
    input  logic              s_add_pinned,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic [5:0]        m_granted_frame,
    output logic [7:0]        m_open_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [6:0]        cfg_wdata
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    pfba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pfba_datapath #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wdata       (cfg_wdata),
        .s_mode          (s_mode),
        .s_frame_index   (s_frame_index),
        .s_add_pinned    (s_add_pinned),
        .m_ok            (m_ok),
        .m_granted_frame (m_granted_frame),
        .m_open_count    (m_open_count)
    );

    // a request transfer and a config transfer never share a cycle
    a_no_dual_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !(cfg_valid && cfg_ready))
        else $error("request and config accepted together");

    // a refused result never carries a frame
    a_fail_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_granted_frame == 6'd0))
        else $error("failed result with nonzero frame");

    // with an empty result slot, a request passes the exec state without a stall
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> ##1 m_valid)
        else $error("result late");

    // nothing is accepted while a request is in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready && !cfg_ready)
        else $error("accept during execution");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit page frame allocator core.
// ----------------------------------------------------------------------------
// A table of directed requests and register writes runs first: reset state,
// allocate and release at the map edges, pin conflicts, unused modes and the
// limit extremes. Random phases follow, each under its own limit and pin
// policy. An in-bench allocator model, or a typed-in row result, scores every
// result in order. The sender runs in bursts and the receiver stalls on its
// own schedule, including one long hold-off that backs the core up.
// ----------------------------------------------------------------------------
module tb_top;
    import pfba_pkg::*;

    localparam int          FRAME_COUNT    = 64;
    localparam int          NUM_PHASES     = 12;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DIR_ROWS       = 33;

    typedef struct packed {
        logic       ok;
        logic [5:0] granted_frame;
        logic [7:0] open_count;
    } alloc_resp_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // request fields, then the typed-in result (when typed is set),
    // then register index and data for write rows
    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         mode;
        logic [5:0]         frame;
        logic               add;
        logic               typed;
        logic               ok;
        logic [5:0]         gr;
        logic [7:0]         cnt;
        logic [CFG_AW-1:0]  reg_idx;
        logic [6:0]         reg_val;
    } dir_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [2:0]        s_mode;
    logic [5:0]        s_frame_index;
    logic              s_add_pinned;
    logic              m_valid;
    logic              m_ready;
    logic              m_ok;
    logic [5:0]        m_granted_frame;
    logic [7:0]        m_open_count;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_addr;
    logic [6:0]        cfg_wdata;

    // allocator model state
    logic [63:0]       frame_used_map;
    logic [63:0]       frame_pin_map;
    logic [6:0]        free_frames;
    logic [6:0]        frames_limit_reg;
    logic              pin_blocks_reg;

    alloc_resp_t       expected_resp_q[$];
    alloc_resp_t       head_resp;
    dir_row_t          directed_tbl [DIR_ROWS];

    int unsigned       mismatches;
    int unsigned       requests_sent;
    int unsigned       results_seen;
    int unsigned       reg_writes;
    int unsigned       burst_left;
    int unsigned       quiet_cycles;
    logic              hold_req;
    logic              hold_done;

    page_frame_bitmap_allocator_core #(
        .FRAME_COUNT (FRAME_COUNT)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_frame_index   (s_frame_index),
        .s_add_pinned    (s_add_pinned),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_granted_frame (m_granted_frame),
        .m_open_count    (m_open_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- allocator model ----------------

    function automatic int unsigned active_frames();
        int unsigned lim;
        lim = frames_limit_reg;
        if (lim > FRAME_COUNT) lim = FRAME_COUNT;
        if (lim > 64) lim = 64;
        return lim;
    endfunction

    function automatic logic [63:0] range_mask(int unsigned lim);
        if (lim >= 64) return '1;
        return (64'd1 << lim) - 64'd1;
    endfunction

    function automatic void recount_free();
        int unsigned lim;
        lim = active_frames();
        free_frames = 7'(lim - $countones(frame_used_map & range_mask(lim)));
    endfunction

    function automatic void reset_model();
        frames_limit_reg = 7'd64;
        pin_blocks_reg   = 1'b1;
        frame_used_map   = '0;
        frame_pin_map    = '0;
        recount_free();
    endfunction

    function automatic void write_model_reg(logic [CFG_AW-1:0] idx, logic [6:0] val);
        if (idx == CFG_FRAMES_IN_USE) begin
            frames_limit_reg = val;
            recount_free();
        end else if (idx == CFG_PINS_BLOCK) begin
            pin_blocks_reg = val[0];
        end
    endfunction

    function automatic alloc_resp_t serve_request(logic [2:0] md, logic [5:0] fi, logic ai);
        alloc_resp_t r;
        int unsigned lim;
        logic [63:0] free_m;
        logic        in_rng;
        int          f;
        r      = '0;
        lim    = active_frames();
        in_rng = (32'(fi) < lim);
        case (md)
            MODE_ALLOC: begin
                free_m = ~frame_used_map & range_mask(lim);
                if (free_m != '0) begin
                    f = 0;
                    while (!free_m[f]) f++;
                    if (!(pin_blocks_reg && frame_pin_map[f])) begin
                        frame_used_map[f] = 1'b1;
                        if (free_frames != 7'd0) free_frames = free_frames - 7'd1;
                        r.ok            = 1'b1;
                        r.granted_frame = 6'(f);
                    end
                end
            end
            MODE_RELEASE: begin
                if (in_rng) begin
                    // counter moves only when the bit really flips
                    if (frame_used_map[fi]) begin
                        frame_used_map[fi] = 1'b0;
                        if (free_frames != 7'd127) free_frames = free_frames + 7'd1;
                    end
                    r.ok = 1'b1;
                end
            end
            MODE_PIN: begin
                if (in_rng && !frame_pin_map[fi]) begin
                    frame_pin_map[fi] = 1'b1;
                    r.ok = 1'b1;
                end
            end
            MODE_UNPIN: begin
                if (in_rng && frame_pin_map[fi]) begin
                    frame_pin_map[fi] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            MODE_COUNT: r.ok = 1'b1;
            default: ;
        endcase
        r.open_count = {1'b0, free_frames};
        if (md == MODE_COUNT && ai) r.open_count = r.open_count + 8'($countones(frame_pin_map));
        return r;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_req(input logic [2:0] md, input logic [5:0] fi, input logic ai,
                            input logic use_typed, input alloc_resp_t typed_resp);
        int unsigned gap;
        alloc_resp_t pred;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= md;
        s_frame_index <= fi;
        s_add_pinned  <= ai;
        do @(posedge aclk); while (s_ready !== 1'b1);
        burst_left--;
        requests_sent++;
        pred = serve_request(md, fi, ai);
        expected_resp_q.push_back(use_typed ? typed_resp : pred);
    endtask

    // register writes only go out once every result is back
    task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [6:0] val);
        s_valid <= 1'b0;
        while (expected_resp_q.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        write_model_reg(idx, val);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic pick_random_req(input int unsigned alloc_weight, output logic [2:0] md,
                                   output logic [5:0] fi, output logic ai);
        int unsigned lim;
        int unsigned r;
        lim = active_frames();
        ai  = 1'($urandom_range(0, 1));
        fi  = 6'($urandom_range(0, 63));
        if (lim != 0 && $urandom_range(0, 9) != 0) fi = 6'($urandom_range(0, lim - 1));
        r = $urandom_range(0, 99);
        if (r < alloc_weight) begin
            md = MODE_ALLOC;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                md = MODE_RELEASE;
                // steer toward a frame that is actually held
                repeat (8) if (lim != 0 && !frame_used_map[fi]) fi = 6'($urandom_range(0, lim - 1));
            end else if (r < 55) begin
                md = MODE_PIN;
            end else if (r < 70) begin
                md = MODE_UNPIN;
            end else if (r < 92) begin
                md = MODE_COUNT;
            end else begin
                md = 3'($urandom_range(5, 7)); // unused mode codes
            end
        end
    endtask

    // ---------------- receiver ----------------

    initial begin
        int unsigned rx_cycle;
        int unsigned style;
        m_ready  = 1'b0;
        rx_cycle = 0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
            end else begin
                style = (rx_cycle / 300) % 4;
                if (style == 0)      m_ready <= 1'b1;
                else if (style == 1) m_ready <= 1'($urandom_range(0, 1));
                else if (style == 2) m_ready <= (rx_cycle % 3 == 0);
                else                 m_ready <= ($urandom_range(0, 99) < 85);
            end
        end
    end

    // ---------------- result checker ----------------

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_resp_q.size() == 0) begin
                $error("result transfer with nothing pending: ok=%0d frame=%0d count=%0d",
                       m_ok, m_granted_frame, m_open_count);
                mismatches++;
            end else begin
                head_resp = expected_resp_q.pop_front();
                results_seen++;
                if (m_ok !== head_resp.ok) begin
                    $error("ok: expected %0d, actual %0d", head_resp.ok, m_ok);
                    mismatches++;
                end
                if (m_granted_frame !== head_resp.granted_frame) begin
                    $error("granted_frame: expected %0d, actual %0d",
                           head_resp.granted_frame, m_granted_frame);
                    mismatches++;
                end
                if (m_open_count !== head_resp.open_count) begin
                    $error("open_count: expected %0d, actual %0d",
                           head_resp.open_count, m_open_count);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("page_frame_bitmap_allocator_core: mismatch");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        logic [2:0]  md;
        logic [5:0]  fi;
        logic        ai;
        int unsigned lim_val;
        logic        pb_val;
        int unsigned alloc_weight;
        int unsigned n_items;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = MODE_COUNT;
        s_frame_index = '0;
        s_add_pinned  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_addr      = CFG_FRAMES_IN_USE;
        cfg_wdata     = '0;
        mismatches    = 0;
        requests_sent = 0;
        results_seen  = 0;
        reg_writes    = 0;
        burst_left    = 0;
        quiet_cycles  = 0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        reset_model();

        directed_tbl = '{
            // reset state, then first-fit from the bottom
            '{ROW_REQ, MODE_COUNT,   6'd0,  1'b0, 1'b1, 1'b1, 6'd0, 8'd64, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_ALLOC,   6'd0,  1'b0, 1'b1, 1'b1, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_ALLOC,   6'd63, 1'b1, 1'b1, 1'b1, 6'd1, 8'd62, CFG_PINS_BLOCK, 7'd0},
            // release of a free frame leaves the count alone
            '{ROW_REQ, MODE_RELEASE, 6'd63, 1'b0, 1'b1, 1'b1, 6'd0, 8'd62, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_RELEASE, 6'd0,  1'b0, 1'b1, 1'b1, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_PIN,     6'd0,  1'b0, 1'b1, 1'b1, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_PIN,     6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            // lowest free frame pinned, policy blocks it
            '{ROW_REQ, MODE_ALLOC,   6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_COUNT,   6'd0,  1'b1, 1'b1, 1'b1, 6'd0, 8'd64, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_UNPIN,   6'd5,  1'b0, 1'b1, 1'b0, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_UNPIN,   6'd0,  1'b0, 1'b1, 1'b1, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_PIN,     6'd63, 1'b0, 1'b1, 1'b1, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_ALLOC,   6'd0,  1'b0, 1'b1, 1'b1, 6'd0, 8'd62, CFG_PINS_BLOCK, 7'd0},
            // unused mode codes
            '{ROW_REQ, 3'd5,         6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 8'd62, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, 3'd6,         6'd42, 1'b1, 1'b1, 1'b0, 6'd0, 8'd62, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, 3'd7,         6'd63, 1'b1, 1'b1, 1'b0, 6'd0, 8'd62, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_COUNT,   6'd63, 1'b1, 1'b1, 1'b1, 6'd0, 8'd63, CFG_PINS_BLOCK, 7'd0},
            // pinned frame granted once the policy is off
            '{ROW_CFG, MODE_COUNT,   6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_PIN,     6'd2,  1'b0, 1'b1, 1'b1, 6'd0, 8'd62, CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_ALLOC,   6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            // oversized limit saturates
            '{ROW_CFG, MODE_COUNT,   6'd0, 1'b0, 1'b0, 1'b0, 6'd0, 8'd0, CFG_FRAMES_IN_USE, 7'd127},
            '{ROW_REQ, MODE_COUNT,   6'd0,  1'b1, 1'b0, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            // zero limit: every frame request fails
            '{ROW_CFG, MODE_COUNT,   6'd0, 1'b0, 1'b0, 1'b0, 6'd0, 8'd0, CFG_FRAMES_IN_USE, 7'd0},
            '{ROW_REQ, MODE_ALLOC,   6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_RELEASE, 6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_PIN,     6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            // one-frame limit, already held: nothing free, high frame out of range
            '{ROW_CFG, MODE_COUNT,   6'd0, 1'b0, 1'b0, 1'b0, 6'd0, 8'd0, CFG_FRAMES_IN_USE, 7'd1},
            '{ROW_REQ, MODE_ALLOC,   6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_UNPIN,   6'd63, 1'b0, 1'b1, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            '{ROW_REQ, MODE_RELEASE, 6'd1,  1'b0, 1'b1, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0},
            '{ROW_CFG, MODE_COUNT,   6'd0, 1'b0, 1'b0, 1'b0, 6'd0, 8'd0, CFG_FRAMES_IN_USE, 7'd64},
            '{ROW_CFG, MODE_COUNT,   6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd1},
            '{ROW_REQ, MODE_COUNT,   6'd0,  1'b1, 1'b0, 1'b0, 6'd0, 8'd0,  CFG_PINS_BLOCK, 7'd0}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (directed_tbl[i].kind == ROW_CFG)
                cfg_write(directed_tbl[i].reg_idx, directed_tbl[i].reg_val);
            else
                send_req(directed_tbl[i].mode, directed_tbl[i].frame, directed_tbl[i].add,
                         directed_tbl[i].typed,
                         '{directed_tbl[i].ok, directed_tbl[i].gr, directed_tbl[i].cnt});
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pb_val = 1'($urandom_range(0, 1));
            case (ph)
                0:       begin lim_val = 64;  pb_val = 1'b1; end
                1:       begin lim_val = 8;   pb_val = 1'b0; end
                2:       begin lim_val = 1;   pb_val = 1'b1; end
                3:       lim_val = 127;
                4:       lim_val = 0;
                5:       begin lim_val = 64;  pb_val = 1'b0; end
                6:       lim_val = 2;
                default: lim_val = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 16)
                                                                : $urandom_range(1, 127);
            endcase
            cfg_write(CFG_FRAMES_IN_USE, 7'(lim_val));
            cfg_write(CFG_PINS_BLOCK, {6'd0, pb_val});
            alloc_weight = (ph == 0) ? 80 : $urandom_range(20, 70);
            n_items      = (lim_val == 0) ? 40 : 150;
            // long receiver stall while the sender keeps pushing
            if (ph == 3) hold_req = 1'b1;
            repeat (n_items) begin
                pick_random_req(alloc_weight, md, fi, ai);
                send_req(md, fi, ai, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (expected_resp_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("run covered %0d requests, %0d results scored, %0d register writes",
                 requests_sent, results_seen, reg_writes);
        $display("limits 0, 1, 2, 8, 64 and saturated; both pin policies; hold-off done=%0d",
                 hold_done);
        if (mismatches == 0 && expected_resp_q.size() == 0)
            $display("page_frame_bitmap_allocator_core: match");
        else
            $display("page_frame_bitmap_allocator_core: mismatch");
        $finish;
    end

endmodule

### sim.f
src/pfba_pkg.sv
src/pfba_ctrl.sv
src/pfba_datapath.sv
src/page_frame_bitmap_allocator_core.sv
tb/sv/tb_top.sv
